// ===== src/two_channel_beep_sequencer_unit_defines.svh =====
// assertion macros for the two-channel beep sequencer checker
// no dependencies; included by the checker file only
`ifndef TWO_CHANNEL_BEEP_SEQUENCER_UNIT_DEFINES_SVH
`define TWO_CHANNEL_BEEP_SEQUENCER_UNIT_DEFINES_SVH

// property checked outside reset
`define TCBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked on every edge, reset included
`define TCBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/tcbs_pkg.sv =====
// shared types, codes and constants of the two-channel beep sequencer
// no dependencies; imported by every rtl module
package tcbs_pkg;

    localparam int DEF_CHANNELS   = 2;
    localparam int DEF_TIMER_BITS = 16;

    localparam logic [15:0] BEEP_ON_RESET = 16'd1500;
    localparam logic [15:0] GAP_OFF_RESET = 16'd500;

    // register indexes of the configuration port
    localparam logic REG_BEEP_ON = 1'b0;
    localparam logic REG_GAP_OFF = 1'b1;

    // mode_select codes of the start mode command
    localparam logic [1:0] SEL_OFF    = 2'd0;
    localparam logic [1:0] SEL_SINGLE = 2'd1;
    localparam logic [1:0] SEL_CONT   = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LEVEL  = 2'd1,
        CMD_MODE   = 2'd2,
        CMD_REPEAT = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        MODE_OFF    = 4'b0001,
        MODE_SINGLE = 4'b0010,
        MODE_CONT   = 4'b0100,
        MODE_REPEAT = 4'b1000
    } mode_t;

    typedef struct packed {
        cmd_t       command;
        logic       channel;
        logic       level_on;
        logic [1:0] mode_select;
        logic [7:0] beep_count;
    } item_t;

    typedef struct packed {
        logic [15:0] beep_on_ms;
        logic [15:0] gap_off_ms;
    } cfg_t;

    typedef struct packed {
        logic level;
        logic active;
    } chan_status_t;

    typedef struct packed {
        logic buzzer1_active;
        logic buzzer0_active;
        logic buzzer1_on;
        logic buzzer0_on;
    } result_t;

endpackage

// ===== src/tcbs_in_reg.sv =====
// input register: unpacks the request and holds it for the update stage
// depends on tcbs_pkg
module tcbs_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // [0] channel, [1] level_on, [3:2] mode_select, [11:4] beep_count, [15:12] zero
    input  logic [15:0]    s_tdata,
    // [1:0] command
    input  logic [1:0]     s_tuser,
    input  logic           advance,
    output logic           item_valid,
    output tcbs_pkg::item_t item
);
    import tcbs_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    // a held request leaves when the update stage takes it
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_next.command     = cmd_t'(s_tuser);
            item_next.channel     = s_tdata[0];
            item_next.level_on    = s_tdata[1];
            item_next.mode_select = s_tdata[3:2];
            item_next.beep_count  = s_tdata[11:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== src/tcbs_channel.sv =====
// state and update logic of one buzzer channel
// depends on tcbs_pkg
module tcbs_channel #(
    parameter int TIMER_BITS = tcbs_pkg::DEF_TIMER_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  tcbs_pkg::item_t        item,
    input  logic                   hit,
    input  tcbs_pkg::cfg_t         cfg,
    output tcbs_pkg::chan_status_t status_next
);
    import tcbs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    mode_t                 mode_reg, mode_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [7:0]            left_reg, left_next, left_dec;
    logic                  level_reg, level_next;
    logic                  on_done, gap_done;

    // saturating millisecond count, then the timeouts are checked against it
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign on_done     = CMP_W'(elapsed_inc) >= CMP_W'(cfg.beep_on_ms);
    assign gap_done    = CMP_W'(elapsed_inc) >= CMP_W'(cfg.gap_off_ms);
    assign left_dec    = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;

    always_comb begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        left_next    = left_reg;
        level_next   = level_reg;
        case (item.command)
            CMD_TICK: begin
                elapsed_next = elapsed_inc;
                case (mode_reg)
                    MODE_SINGLE: begin
                        if (on_done) begin
                            mode_next    = MODE_OFF;
                            elapsed_next = '0;
                            left_next    = 8'd0;
                            level_next   = 1'b0;
                        end
                    end
                    MODE_REPEAT: begin
                        if (level_reg && on_done) begin
                            level_next   = 1'b0;
                            elapsed_next = '0;
                            left_next    = left_dec;
                            if (left_dec == 8'd0) begin
                                mode_next = MODE_OFF;
                            end
                        end else if (!level_reg && left_reg != 8'd0 && gap_done) begin
                            level_next   = 1'b1;
                            elapsed_next = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_LEVEL: begin
                if (hit) begin
                    mode_next    = item.level_on ? MODE_CONT : MODE_OFF;
                    elapsed_next = '0;
                    left_next    = 8'd0;
                    level_next   = item.level_on;
                end
            end
            CMD_MODE: begin
                if (hit) begin
                    elapsed_next = '0;
                    left_next    = 8'd0;
                    case (item.mode_select)
                        SEL_SINGLE: begin
                            mode_next  = MODE_SINGLE;
                            level_next = 1'b1;
                        end
                        SEL_CONT: begin
                            mode_next  = MODE_CONT;
                            level_next = 1'b1;
                        end
                        default: begin
                            mode_next  = MODE_OFF;
                            level_next = 1'b0;
                        end
                    endcase
                end
            end
            CMD_REPEAT: begin
                if (hit) begin
                    elapsed_next = '0;
                    if (item.beep_count == 8'd0) begin
                        mode_next  = MODE_OFF;
                        left_next  = 8'd0;
                        level_next = 1'b0;
                    end else begin
                        mode_next  = MODE_REPEAT;
                        left_next  = item.beep_count;
                        level_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_OFF;
            elapsed_reg <= '0;
            left_reg    <= 8'd0;
            level_reg   <= 1'b0;
        end else if (advance) begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            left_reg    <= left_next;
            level_reg   <= level_next;
        end
    end

    assign status_next.level  = level_next;
    assign status_next.active = (mode_next != MODE_OFF);
endmodule

// ===== src/tcbs_out_reg.sv =====
// result register: holds the levels and active flags until taken
// depends on tcbs_pkg
module tcbs_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  tcbs_pkg::result_t result_next,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] buzzer0_on, [1] buzzer1_on, [2] buzzer0_active, [3] buzzer1_active,
    // [7:4] zero
    output logic [7:0]        m_tdata
);
    import tcbs_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, result_reg};
endmodule

// ===== src/two_channel_beep_sequencer_unit.sv =====
// top level of the two-channel beep sequencer
// depends on tcbs_pkg, tcbs_in_reg, tcbs_channel, tcbs_out_reg
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata[15:0], s_tuser[1:0] = command
//  m_       out  m_tvalid/m_tready    m_tdata[7:0] = levels and active flags
//  cfg_     in   cfg_valid/cfg_ready  cfg_index (0 beep_on_ms, 1 gap_off_ms), cfg_data
//
// one request per cycle while m_ does not stall: input register, channel update,
// result register; a request passes the input register, then the result register
// the update stage moves whenever the result register is empty or being taken,
// so a stall on m_ only holds s_tready low once both registers are full
// synchronous active-low reset clears all channel state and loads the timing registers with their defaults
module two_channel_beep_sequencer_unit #(
    parameter int CHANNELS   = tcbs_pkg::DEF_CHANNELS,
    parameter int TIMER_BITS = tcbs_pkg::DEF_TIMER_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] channel, [1] level_on, [3:2] mode_select, [11:4] beep_count, [15:12] zero
    input  logic [15:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] buzzer0_on, [1] buzzer1_on, [2] buzzer0_active, [3] buzzer1_active,
    // [7:4] zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import tcbs_pkg::*;

    logic         item_valid;
    item_t        item;
    logic         advance;
    cfg_t         cfg_reg;
    chan_status_t status_next [CHANNELS];
    result_t      result_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beep_on_ms <= BEEP_ON_RESET;
            cfg_reg.gap_off_ms <= GAP_OFF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BEEP_ON: cfg_reg.beep_on_ms <= cfg_data;
                REG_GAP_OFF: cfg_reg.gap_off_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign advance = item_valid && (!m_tvalid || m_tready);

    tcbs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic hit;
        // a command to a channel beyond the configured count matches nothing
        assign hit = (32'(item.channel) == c);

        tcbs_channel #(
            .TIMER_BITS (TIMER_BITS)
        ) u_channel (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (advance),
            .item        (item),
            .hit         (hit),
            .cfg         (cfg_reg),
            .status_next (status_next[c])
        );
    end

    assign result_next.buzzer0_on     = status_next[0].level;
    assign result_next.buzzer0_active = status_next[0].active;

    if (CHANNELS > 1) begin : g_second
        assign result_next.buzzer1_on     = status_next[1].level;
        assign result_next.buzzer1_active = status_next[1].active;
    end else begin : g_no_second
        assign result_next.buzzer1_on     = 1'b0;
        assign result_next.buzzer1_active = 1'b0;
    end

    tcbs_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .result_next (result_next),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );
endmodule

// ===== src/tcbs_checker.sv =====
// port-level checks of the two-channel beep sequencer, bound to the top level
// depends on two_channel_beep_sequencer_unit_defines.svh
`include "two_channel_beep_sequencer_unit_defines.svh"

module tcbs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    // a held result does not change until taken
    `TCBS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    // input side backs up only behind a stalled result
    `TCBS_ASSERT(a_backpressure, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled without output stall")
    // a sounding buzzer is always in an active mode
    `TCBS_ASSERT(a_level_active, aclk, aresetn, m_tvalid |-> (!m_tdata[0] || m_tdata[2]) && (!m_tdata[1] || m_tdata[3]), "buzzer on while inactive")
    // reset empties the result register
    `TCBS_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
endmodule

bind two_channel_beep_sequencer_unit tcbs_checker u_tcbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
